// ----- rtl/ftc_pkg.sv -----
// Shared types and constants of the triangle frustum clipper.
// No dependencies; the front, back, top level and testbench import this package.
package ftc_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vtx;

    typedef struct packed {
        t_vtx [2:0] v;
    } t_tri;

    // Configuration register indexes.
    localparam logic [1:0] REG_TAN_H = 2'd0;
    localparam logic [1:0] REG_TAN_V = 2'd1;
    localparam logic [1:0] REG_NEAR  = 2'd2;
    localparam logic [1:0] REG_FAR   = 2'd3;

    // Clip planes, in processing order.
    localparam logic [2:0] PL_NEAR   = 3'd0;
    localparam logic [2:0] PL_FAR    = 3'd1;
    localparam logic [2:0] PL_LEFT   = 3'd2;
    localparam logic [2:0] PL_RIGHT  = 3'd3;
    localparam logic [2:0] PL_BOTTOM = 3'd4;
    localparam logic [2:0] PL_TOP    = 3'd5;

    localparam int MIN_POLY = 3;
    localparam int MAG_W    = 33;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PSTART,
        S_PMUL,
        S_PVAL,
        S_CLOAD,
        S_CMUL,
        S_CVAL,
        S_DECIDE,
        S_DIV,
        S_XWR,
        S_CWR,
        S_NEXT,
        S_EMIT,
        S_CULL
    } t_state;

endpackage

// ----- rtl/ftc_front.sv -----
// Input side of the clipper: a two-entry triangle queue that decouples the
// producer from the clip sequencer. Depends on ftc_pkg.
module ftc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ftc_pkg::t_tri i_tri,
    output logic          o_full,
    output logic          o_valid,
    output ftc_pkg::t_tri o_head,
    input  logic          i_pop
);
    import ftc_pkg::*;

    t_tri       r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr  = push_ok ? ~r_wr : r_wr;
        n_rd  = pop_ok ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_tri;
        end
    end

endmodule

// ----- rtl/ftc_back.sv -----
// Clip sequencer: walks the polygon through the six planes with a shared
// multiplier, three serial multiply-divide lanes and a result register.
// Depends on ftc_pkg.
module ftc_back #(
    parameter int MAX_POLY_VERTICES = 9,
    parameter int FRAC_BITS         = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_tan_h,
    input  logic [31:0]   i_tan_v,
    input  logic [30:0]   i_near,
    input  logic [30:0]   i_far,
    input  logic          i_q_valid,
    input  ftc_pkg::t_tri i_q_head,
    output logic          o_q_pop,
    output logic          o_valid,
    output ftc_pkg::t_vtx o_vtx,
    output logic [3:0]    o_vertex_number,
    output logic          o_culled,
    output logic          o_last_vertex,
    input  logic          i_pop
);
    import ftc_pkg::*;

    localparam int PW = 66 - FRAC_BITS;              // plane value width
    localparam int DW = PW + 1;                      // denominator width
    localparam int TW = DW + 2;                      // divider step width
    localparam int QW = MAG_W + 1;
    localparam int IW = $clog2(MAX_POLY_VERTICES);
    localparam int CW = $clog2(MAX_POLY_VERTICES + 1);

    t_state r_state, n_state;

    t_vtx                r_buf [2][MAX_POLY_VERTICES];
    logic                r_src;
    logic [IW-1:0]       r_idx;
    logic [CW-1:0]       r_n, r_cnt;
    logic [2:0]          r_plane;
    t_vtx                r_prev, r_cur;
    logic signed [63:0]  r_prod;
    logic signed [PW-1:0] r_vprev, r_vcur;
    logic [DW-1:0]       r_den;
    logic [PW-1:0]       r_ap;
    logic [5:0]          r_step;
    logic [MAG_W-1:0]    r_magd [3];
    logic                r_dneg [3];
    logic [DW-1:0]       r_rem [3];
    logic [QW-1:0]       r_quo [3];

    // Control from the output decoder.
    logic          wr_en;
    t_vtx          wr_vtx;
    logic          slot_free;
    logic [CW-1:0] n_last;
    logic [IW-1:0] rd_addr;
    t_vtx          rd_vtx;
    logic          idx_last;

    // Plane evaluation.
    t_vtx                 ev;
    logic signed [32:0]   tan_s;
    logic signed [63:0]   prod_rnd, rp_full;
    logic signed [PW-1:0] rp, ex, ey, ez, pv;

    // Divider step and crossing point.
    logic [TW-1:0]        st_t [3];
    logic [TW-1:0]        st_r [3];
    logic [1:0]           st_k [3];
    logic [QW-1:0]        q_rnd [3];
    logic signed [31:0]   xc [3];
    logic signed [32:0]   dd [3];
    logic [PW-1:0]        mvp, mvc;
    logic                 cin, pin;

    assign slot_free = !o_valid || i_pop;
    assign n_last    = r_n - CW'(1);
    assign rd_addr   = (r_state == S_PSTART) ? n_last[IW-1:0] : r_idx;
    assign rd_vtx    = r_buf[r_src][rd_addr];
    assign idx_last  = ({{(CW-IW){1'b0}}, r_idx} == n_last) || (CW == IW && 1'b0);
    assign cin       = !r_vcur[PW-1];
    assign pin       = !r_vprev[PW-1];

    // Plane value of the vertex under evaluation.
    always_comb begin
        ev       = ((r_state == S_PMUL) || (r_state == S_PVAL)) ? r_prev : r_cur;
        tan_s    = ((r_plane == PL_LEFT) || (r_plane == PL_RIGHT)) ?
                   $signed({1'b0, i_tan_h}) : $signed({1'b0, i_tan_v});
        prod_rnd = r_prod + (64'sd1 <<< (FRAC_BITS - 1));
        rp_full  = prod_rnd >>> FRAC_BITS;
        rp       = rp_full[PW-1:0];
        ex       = PW'(ev.x);
        ey       = PW'(ev.y);
        ez       = PW'(ev.z);
        case (r_plane)
            PL_NEAR:   pv = ex - $signed({{(PW-31){1'b0}}, i_near});
            PL_FAR:    pv = $signed({{(PW-31){1'b0}}, i_far}) - ex;
            PL_LEFT:   pv = ey + rp;
            PL_RIGHT:  pv = rp - ey;
            PL_BOTTOM: pv = ez + rp;
            default:   pv = rp - ez;
        endcase
        mvp = r_vprev[PW-1] ? PW'(-r_vprev) : PW'(r_vprev);
        mvc = r_vcur[PW-1]  ? PW'(-r_vcur)  : PW'(r_vcur);
    end

    // One step of (|d| * ap) / den per lane, most significant bit of |d| first.
    // The partial remainder stays below den, so each step adds at most 2 to q.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            st_t[k] = {r_rem[k], 1'b0} + (r_magd[k][r_step] ? TW'(r_ap) : TW'(0));
            if (st_t[k] >= {r_den, 1'b0}) begin
                st_r[k] = st_t[k] - {r_den, 1'b0};
                st_k[k] = 2'd2;
            end else if (st_t[k] >= TW'(r_den)) begin
                st_r[k] = st_t[k] - TW'(r_den);
                st_k[k] = 2'd1;
            end else begin
                st_r[k] = st_t[k];
                st_k[k] = 2'd0;
            end
            q_rnd[k] = r_quo[k] + QW'({r_rem[k], 1'b0} >= {1'b0, r_den});
        end
        dd[0] = 33'(r_cur.x) - 33'(r_prev.x);
        dd[1] = 33'(r_cur.y) - 33'(r_prev.y);
        dd[2] = 33'(r_cur.z) - 33'(r_prev.z);
        xc[0] = r_dneg[0] ? r_prev.x - 32'(q_rnd[0]) : r_prev.x + 32'(q_rnd[0]);
        xc[1] = r_dneg[1] ? r_prev.y - 32'(q_rnd[1]) : r_prev.y + 32'(q_rnd[1]);
        xc[2] = r_dneg[2] ? r_prev.z - 32'(q_rnd[2]) : r_prev.z + 32'(q_rnd[2]);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_q_valid) n_state = S_LOAD;
            S_LOAD:   if (r_idx == IW'(2)) n_state = S_PSTART;
            S_PSTART: n_state = S_PMUL;
            S_PMUL:   n_state = S_PVAL;
            S_PVAL:   n_state = S_CLOAD;
            S_CLOAD:  n_state = S_CMUL;
            S_CMUL:   n_state = S_CVAL;
            S_CVAL:   n_state = S_DECIDE;
            S_DECIDE: n_state = (cin != pin) ? S_DIV : (cin ? S_CWR : S_NEXT);
            S_DIV:    if (r_step == 6'd0) n_state = S_XWR;
            S_XWR:    n_state = cin ? S_CWR : S_NEXT;
            S_CWR:    n_state = S_NEXT;
            S_NEXT: begin
                if (!idx_last) begin
                    n_state = S_CLOAD;
                end else if (r_cnt < CW'(MIN_POLY)) begin
                    n_state = S_CULL;
                end else if (r_plane == PL_TOP) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PSTART;
                end
            end
            S_EMIT:   if (slot_free && idx_last) n_state = S_IDLE;
            S_CULL:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Decoded controls.
    always_comb begin
        o_q_pop = 1'b0;
        wr_en   = 1'b0;
        wr_vtx  = r_cur;
        unique case (r_state)
            S_LOAD:  o_q_pop = (r_idx == IW'(2));
            S_XWR: begin
                wr_en    = 1'b1;
                wr_vtx.x = xc[0];
                wr_vtx.y = xc[1];
                wr_vtx.z = xc[2];
            end
            S_CWR:   wr_en = 1'b1;
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_EMIT || r_state == S_CULL) && slot_free) begin
                o_valid <= 1'b1;
            end else if (i_pop) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_cnt < CW'(MAX_POLY_VERTICES)) begin
            r_buf[~r_src][r_cnt[IW-1:0]] <= wr_vtx;
        end
        if (wr_en) begin
            r_cnt <= (r_cnt < CW'(MAX_POLY_VERTICES)) ? r_cnt + CW'(1) : r_cnt;
        end
        case (r_state)
            S_IDLE: begin
                r_idx   <= '0;
                r_src   <= 1'b0;
                r_plane <= PL_NEAR;
            end
            S_LOAD: begin
                r_buf[0][r_idx] <= i_q_head.v[r_idx[1:0]];
                r_idx           <= r_idx + IW'(1);
                r_n             <= CW'(3);
            end
            S_PSTART: begin
                r_prev <= rd_vtx;
                r_idx  <= '0;
                r_cnt  <= '0;
            end
            S_PMUL, S_CMUL: r_prod <= ev.x * tan_s;
            S_PVAL:  r_vprev <= pv;
            S_CLOAD: r_cur   <= rd_vtx;
            S_CVAL:  r_vcur  <= pv;
            S_DECIDE: begin
                r_ap   <= mvp;
                r_den  <= DW'(mvp) + DW'(mvc);
                r_step <= 6'(MAG_W - 1);
                for (int k = 0; k < 3; k++) begin
                    r_magd[k] <= dd[k][32] ? MAG_W'(-dd[k]) : MAG_W'(dd[k]);
                    r_dneg[k] <= dd[k][32];
                    r_rem[k]  <= '0;
                    r_quo[k]  <= '0;
                end
            end
            S_DIV: begin
                r_step <= r_step - 6'd1;
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= st_r[k][DW-1:0];
                    r_quo[k] <= {r_quo[k][QW-2:0], 1'b0} + QW'(st_k[k]);
                end
            end
            S_NEXT: begin
                r_prev  <= r_cur;
                r_vprev <= r_vcur;
                if (!idx_last) begin
                    r_idx <= r_idx + IW'(1);
                end else begin
                    r_idx   <= '0;
                    r_n     <= r_cnt;
                    r_src   <= ~r_src;
                    r_plane <= r_plane + 3'd1;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_vtx           <= rd_vtx;
                    o_vertex_number <= 4'(r_idx);
                    o_culled        <= 1'b0;
                    o_last_vertex   <= idx_last;
                    r_idx           <= r_idx + IW'(1);
                end
            end
            S_CULL: begin
                if (slot_free) begin
                    o_vtx           <= '0;
                    o_vertex_number <= 4'd0;
                    o_culled        <= 1'b1;
                    o_last_vertex   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/triangle_frustum_clipper.sv -----
// The clip sequencer takes one triangle at a time from a two-triangle queue and
// walks it through the six planes: each vertex entering a plane is evaluated, each
// kept vertex is written, and each crossing adds a serial multiply-divide, which
// sets most of the time per triangle. Results then come out one per cycle when pop is held.
// Reset (i_rst_n low at a clock edge) empties the triangle queue and the result
// register and restores the configuration registers; polygon buffers are not cleared.
module triangle_frustum_clipper #(
    parameter int MAX_POLY_VERTICES = 9,
    parameter int FRAC_BITS         = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_c_x,
    input  logic signed [31:0] i_c_y,
    input  logic signed [31:0] i_c_z,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [3:0]         o_vertex_number,
    output logic               o_culled,
    output logic               o_last_vertex,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ftc_pkg::*;

    logic [31:0] r_tan_h, r_tan_v;
    logic [30:0] r_near, r_far;
    t_tri        tri_in, q_head;
    logic        q_valid, q_pop, out_valid;
    t_vtx        out_vtx;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tan_h <= 32'd65536;
            r_tan_v <= 32'd36864;
            r_near  <= 31'd655360;
            r_far   <= 31'h7FFF_FFFF;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_TAN_H: r_tan_h <= pwdata;
                REG_TAN_V: r_tan_v <= pwdata;
                REG_NEAR:  r_near  <= pwdata[30:0];
                REG_FAR:   r_far   <= pwdata[30:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TAN_H: prdata = r_tan_h;
            REG_TAN_V: prdata = r_tan_v;
            REG_NEAR:  prdata = {1'b0, r_near};
            default:   prdata = {1'b0, r_far};
        endcase
    end

    assign tri_in.v[0] = '{x: i_a_x, y: i_a_y, z: i_a_z};
    assign tri_in.v[1] = '{x: i_b_x, y: i_b_y, z: i_b_z};
    assign tri_in.v[2] = '{x: i_c_x, y: i_c_y, z: i_c_z};

    ftc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_tri   (tri_in),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    ftc_back #(
        .MAX_POLY_VERTICES (MAX_POLY_VERTICES),
        .FRAC_BITS         (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tan_h         (r_tan_h),
        .i_tan_v         (r_tan_v),
        .i_near          (r_near),
        .i_far           (r_far),
        .i_q_valid       (q_valid),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .o_valid         (out_valid),
        .o_vtx           (out_vtx),
        .o_vertex_number (o_vertex_number),
        .o_culled        (o_culled),
        .o_last_vertex   (o_last_vertex),
        .i_pop           (i_pop)
    );

    assign o_empty = !out_valid;
    assign o_out_x = out_vtx.x;
    assign o_out_y = out_vtx.y;
    assign o_out_z = out_vtx.z;

endmodule

// ----- rtl/ftc_checker.sv -----
// Port-level checks of the triangle frustum clipper, bound to the top level.
// Depends only on the top level's ports.
module ftc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_empty,
    input logic               i_pop,
    input logic signed [31:0] o_out_x,
    input logic signed [31:0] o_out_y,
    input logic signed [31:0] o_out_z,
    input logic [3:0]         o_vertex_number,
    input logic               o_culled,
    input logic               o_last_vertex
);

    // A culled item is a lone, all-zero, final item.
    a_culled_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_culled |-> o_last_vertex && o_vertex_number == 4'd0 &&
        o_out_x == 32'sd0 && o_out_y == 32'sd0 && o_out_z == 32'sd0)
        else $error("culled item malformed");

    // After a non-final vertex is taken, the next one shown follows it.
    a_numbering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && $past(i_pop && !o_empty && !o_last_vertex) |->
        o_vertex_number == $past(o_vertex_number) + 4'd1 && !o_culled)
        else $error("vertex numbering broken");

    // A polygon that was not culled has at least three vertices.
    a_min_poly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_last_vertex && !o_culled |-> o_vertex_number >= 4'd2)
        else $error("polygon too small");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("results present after reset");

endmodule

bind triangle_frustum_clipper ftc_checker u_ftc_checker (.*);

// ----- bench/tb_triangle_frustum_clipper.sv -----
// Self-checking testbench for the triangle frustum clipper.
// Needs ftc_pkg.sv, ftc_front.sv, ftc_back.sv and triangle_frustum_clipper.sv from rtl.
// A fixed-point clip predictor runs alongside the block; every popped vertex is compared.
module tb_triangle_frustum_clipper;
    timeunit 1ns;
    timeprecision 1ps;
    import ftc_pkg::*;

    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        longint c[3];
    } pt_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [3:0]         num;
        logic               culled;
        logic               last;
    } vert_res_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [31:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic [3:0]         o_vertex_number;
    logic               o_culled, o_last_vertex;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    triangle_frustum_clipper DUT (.*);

    always #1 i_clk = ~i_clk;

    // Configuration as the predictor sees it.
    logic [31:0] cfg_tan_h = 32'd65536;
    logic [31:0] cfg_tan_v = 32'd36864;
    logic [30:0] cfg_near  = 31'd655360;
    logic [30:0] cfg_far   = 31'h7FFF_FFFF;

    vert_res_t expected_verts[$];
    int        errors = 0;
    bit        stall_on = 1'b1;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic longint scaled_x(longint x, logic [31:0] t);
        longint p;
        p = x * longint'({32'b0, t}) + (64'sd1 << 15);
        return p >>> 16;
    endfunction

    function automatic longint plane_val(pt_t v, logic [2:0] pl);
        case (pl)
            PL_NEAR:   return v.c[0] - longint'({33'b0, cfg_near});
            PL_FAR:    return longint'({33'b0, cfg_far}) - v.c[0];
            PL_LEFT:   return v.c[1] + scaled_x(v.c[0], cfg_tan_h);
            PL_RIGHT:  return scaled_x(v.c[0], cfg_tan_h) - v.c[1];
            PL_BOTTOM: return v.c[2] + scaled_x(v.c[0], cfg_tan_v);
            default:   return scaled_x(v.c[0], cfg_tan_v) - v.c[2];
        endcase
    endfunction

    function automatic pt_t cross_pt(pt_t p, pt_t c, longint vp, longint vc);
        pt_t o;
        logic [127:0] num, den, q, r;
        longint ap, d;
        ap = (vp < 0) ? -vp : vp;
        den = 128'(ap) + 128'((vc < 0) ? -vc : vc);
        for (int k = 0; k < 3; k++) begin
            d = c.c[k] - p.c[k];
            num = 128'((d < 0) ? -d : d) * 128'(ap);
            q = num / den;
            r = num % den;
            if (2 * r >= den) q++;
            o.c[k] = (d < 0) ? p.c[k] - longint'(q) : p.c[k] + longint'(q);
        end
        return o;
    endfunction

    // Clips one triangle and queues the vertices the block must produce.
    function automatic void predict_clip(input t_vtx tri_in[3]);
        pt_t    poly[16], nxt[16];
        int     n, cnt;
        longint vprev, vcur;
        pt_t    prev;
        vert_res_t r;
        n = 3;
        for (int i = 0; i < 3; i++) begin
            poly[i].c[0] = tri_in[i].x;
            poly[i].c[1] = tri_in[i].y;
            poly[i].c[2] = tri_in[i].z;
        end
        for (int pl = 0; pl < 6; pl++) begin
            cnt = 0;
            prev = poly[n - 1];
            vprev = plane_val(prev, 3'(pl));
            for (int i = 0; i < n; i++) begin
                vcur = plane_val(poly[i], 3'(pl));
                if ((vcur >= 0) != (vprev >= 0) && cnt < 9)
                    nxt[cnt++] = cross_pt(prev, poly[i], vprev, vcur);
                if (vcur >= 0 && cnt < 9)
                    nxt[cnt++] = poly[i];
                prev = poly[i];
                vprev = vcur;
            end
            n = cnt;
            poly = nxt;
            if (n < MIN_POLY) begin
                r = '{x: 0, y: 0, z: 0, num: 0, culled: 1'b1, last: 1'b1};
                expected_verts.push_back(r);
                return;
            end
        end
        for (int i = 0; i < n; i++) begin
            r.x = poly[i].c[0][31:0];
            r.y = poly[i].c[1][31:0];
            r.z = poly[i].c[2][31:0];
            r.num = 4'(i);
            r.culled = 1'b0;
            r.last = (i == n - 1);
            expected_verts.push_back(r);
        end
    endfunction

    task automatic send_tri(input t_vtx t[3]);
        i_a_x <= t[0].x; i_a_y <= t[0].y; i_a_z <= t[0].z;
        i_b_x <= t[1].x; i_b_y <= t[1].y; i_b_z <= t[1].z;
        i_c_x <= t[2].x; i_c_y <= t[2].y; i_c_z <= t[2].z;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        predict_clip(t);
        if (stall_on && $urandom_range(0, 2) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_pts(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        t_vtx t[3];
        t[0] = '{ax, ay, az};
        t[1] = '{bx, by, bz};
        t[2] = '{cx, cy, cz};
        send_tri(t);
    endtask

    // Waits until every queued vertex has come out and the sequencer is quiet.
    task automatic drain();
        i_push <= 1'b0;
        while (expected_verts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TAN_H: cfg_tan_h = val;
            REG_TAN_V: cfg_tan_v = val;
            REG_NEAR:  cfg_near = val[30:0];
            default:   cfg_far = val[30:0];
        endcase
        want = (idx == REG_TAN_H || idx == REG_TAN_V) ? val : {1'b0, val[30:0]};
        // Read back the register just written.
        penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != want)
            report($sformatf("reg %0d read %h, wrote %h", idx, prdata, want));
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] th, tv, nd, fd);
        write_reg(REG_TAN_H, th);
        write_reg(REG_TAN_V, tv);
        write_reg(REG_NEAR, nd);
        write_reg(REG_FAR, fd);
    endtask

    function automatic t_vtx rand_vtx(input bit wild);
        t_vtx v;
        int   span;
        if (wild) begin
            v.x = $urandom; v.y = $urandom; v.z = $urandom;
        end else begin
            v.x = int'($urandom_range(0, 60 << 16)) - (4 << 16);
            span = (v.x < 0 ? -v.x : v.x) * 3 / 2 + (1 << 16);
            v.y = int'($urandom_range(0, 2 * span)) - span;
            v.z = int'($urandom_range(0, 2 * span)) - span;
        end
        return v;
    endfunction

    task automatic test_directed();
        int f;
        f = 1 << 16;
        send_pts(20*f, 0, 0, 30*f, 5*f, 2*f, 25*f, -3*f, -2*f);        // fully inside
        send_pts(-5*f, 0, 0, -6*f, f, f, -7*f, -f, 0);                 // behind near, culled
        send_pts(5*f, 0, 0, 30*f, 2*f, 0, 30*f, -2*f, f);              // crosses near
        send_pts(20*f, -100*f, -100*f, 20*f, 100*f, 0, 20*f, 0, 100*f); // cut by four sides
        send_pts(5*f, -40*f, 0, 40*f, 60*f, -50*f, 40*f, -60*f, 50*f); // many crossings
        send_pts(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pts(20*f, f, f, 20*f, f, f, 20*f, f, f);                  // degenerate point
        send_pts(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 30*f, 0, 0);
        send_pts(10*f, 10*f, 0, 10*f, -10*f, 0, 50*f, 0, 28*f);        // vertices on planes
        send_pts(-1, -1, -1, 32'h7FFF_FFFF, 0, 0, 15*f, -1, 1);
        drain();
    endtask

    task automatic test_random(input int count);
        t_vtx t[3];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) t[i] = rand_vtx($urandom_range(0, 4) == 0);
            send_tri(t);
        end
        drain();
    endtask

    task automatic test_extreme_config();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        test_directed();
        test_random(30);
        set_config(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);                 // everything culled
        test_random(10);
        set_config(32'h0, 32'h1_0000, 32'h1_0000, 32'h7FFF_FFFF);
        test_random(15);
    endtask

    task automatic test_mixed_config();
        set_config(32'h2_0000, 32'h0_8000, 32'h3_0000, 32'h28_0000);    // tight far plane
        test_random(40);
        set_config($urandom, $urandom_range(0, 32'h4_0000),
                   $urandom_range(0, 32'h10_0000), $urandom_range(32'h10_0000, 32'h7FFF_FFFF));
        test_random(40);
        set_config(32'h1_0000, 32'h9000, 32'hA_0000, 32'h7FFF_FFFF);
    endtask

    always @(posedge i_clk) begin
        vert_res_t e;
        if (i_pop && !o_empty) begin
            if (expected_verts.size() == 0) begin
                report("vertex with nothing expected");
            end else begin
                e = expected_verts.pop_front();
                if (o_out_x !== e.x) report($sformatf("x %h want %h", o_out_x, e.x));
                if (o_out_y !== e.y) report($sformatf("y %h want %h", o_out_y, e.y));
                if (o_out_z !== e.z) report($sformatf("z %h want %h", o_out_z, e.z));
                if (o_vertex_number !== e.num)
                    report($sformatf("vertex_number %0d want %0d", o_vertex_number, e.num));
                if (o_culled !== e.culled) report($sformatf("culled %b", o_culled));
                if (o_last_vertex !== e.last) report($sformatf("last %b", o_last_vertex));
            end
        end
        if (!i_rst_n)
            i_pop <= 1'b0;
        else if (stall_on && $urandom_range(0, 5) == 0)
            i_pop <= 1'b0;
        else if (stall_on && !i_pop && $urandom_range(0, 1) == 0)
            i_pop <= 1'b0;   // lengthens a stall into a burst
        else
            i_pop <= 1'b1;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(80);
        test_extreme_config();
        test_mixed_config();
        stall_on = 1'b0;
        test_random(70);
        if (expected_verts.size() != 0) report("vertices never produced");
        if (errors == 0)
            $display("[triangle_frustum_clipper] OK");
        else
            $display("[triangle_frustum_clipper] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[triangle_frustum_clipper] ERROR");
        $finish;
    end

endmodule

// ----- triangle_frustum_clipper.f -----
rtl/ftc_pkg.sv
rtl/ftc_front.sv
rtl/ftc_back.sv
rtl/triangle_frustum_clipper.sv
rtl/ftc_checker.sv
bench/tb_triangle_frustum_clipper.sv
